### src/assr_pkg.sv
// ----------------------------------------------------------------------------
// assr_pkg - shared definitions for the angle seek speed ramp
// Register codes, reset values, fixed-point constants and the structures that
// travel between the configuration block, the ramp stage and the output buffer.
// ----------------------------------------------------------------------------
package assr_pkg;

	// Default encoder counts per mechanical turn.
	localparam int TICKS_PER_TURN_DEF = 9843;

	// One full turn and half a turn in Q8 degrees.
	localparam int FULL_TURN_Q8 = 92160;
	localparam int HALF_TURN_Q8 = 46080;
	localparam int Q8_TURN_BITS = 17;

	// floor(x / 1000) = (x * RECIP_1000) >> SHIFT_1000, exact for x below 2^24.
	localparam logic [24:0] RECIP_1000 = 25'd17179870;
	localparam int          SHIFT_1000 = 34;
	// floor(x / 180) = (x * RECIP_180) >> SHIFT_180, exact for x below 2^16.
	localparam logic [15:0] RECIP_180  = 16'd46604;
	localparam int          SHIFT_180  = 23;

	// Configuration register codes.
	typedef enum logic [7:0] {
		CFG_MAX_SPEED  = 8'd0,
		CFG_ACCEL_RATE = 8'd1,
		CFG_MIN_SPEED  = 8'd2,
		CFG_DEADBAND   = 8'd3
	} cfg_reg_t;

	localparam logic [7:0]  MAX_SPEED_RST  = 8'd245;
	localparam logic [15:0] ACCEL_RATE_RST = 16'd1100;
	localparam logic [7:0]  MIN_SPEED_RST  = 8'd25;
	localparam logic [3:0]  DEADBAND_RST   = 4'd1;

	typedef struct packed {
		logic [7:0]  max_speed;
		logic [15:0] accel_rate;
		logic [7:0]  min_speed;
		logic [3:0]  deadband;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic signed [8:0] motor_speed;
		logic              speed_sent;
		logic signed [8:0] angle_error;
	} res_t;

endpackage

### src/assr_cfg.sv
// ----------------------------------------------------------------------------
// assr_cfg - configuration registers
// Holds the four control registers; a write to an unknown index is dropped.
// ----------------------------------------------------------------------------
module assr_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output assr_pkg::cfg_t  cfg
);
	import assr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed  <= MAX_SPEED_RST;
			cfg_q.accel_rate <= ACCEL_RATE_RST;
			cfg_q.min_speed  <= MIN_SPEED_RST;
			cfg_q.deadband   <= DEADBAND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_SPEED:  cfg_q.max_speed  <= cfg_data[7:0];
				CFG_ACCEL_RATE: cfg_q.accel_rate <= cfg_data;
				CFG_MIN_SPEED:  cfg_q.min_speed  <= cfg_data[7:0];
				CFG_DEADBAND:   cfg_q.deadband   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### src/assr_cdiv.sv
// ----------------------------------------------------------------------------
// assr_cdiv - pipelined unsigned division by a constant
// Four stages: split reciprocal products, sum and shift, back-multiply, and a
// single compare-and-subtract correction of quotient and remainder.
// ----------------------------------------------------------------------------
module assr_cdiv #(
	parameter int NW = 32,
	parameter int D  = assr_pkg::TICKS_PER_TURN_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [NW-1:0]          a,
	output logic [NW-1:0]          q,
	output logic [$clog2(D)-1:0]   r
);
	localparam int RW = $clog2(D);
	localparam int K  = NW + $clog2(D);
	localparam int MW = NW + 1;
	localparam int HW = (MW + 1) / 2;
	localparam logic [63:0]   MFULL = (64'd1 << K) / 64'(D);
	localparam logic [MW-1:0] M     = MFULL[MW-1:0];
	localparam logic [HW-1:0] ML    = M[HW-1:0];
	localparam logic [MW-HW-1:0] MH = M[MW-1:HW];

	logic [NW+HW-1:0]    pl_s1;
	logic [NW+MW-HW-1:0] ph_s1;
	logic [NW-1:0]       a_s1, a_s2, a_s3;
	logic [NW-1:0]       q_s2, q_s3, qd_s3, q_s4;
	logic [RW-1:0]       r_s4;
	logic [NW+MW-1:0]    sum;
	logic [NW-1:0]       r_est;

	// The estimate is the true quotient or one below it.
	assign sum   = (NW+MW)'(pl_s1) + ((NW+MW)'(ph_s1) << HW);
	assign r_est = a_s3 - qd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= (NW+HW)'(a) * (NW+HW)'(ML);
			ph_s1 <= (NW+MW-HW)'(a) * (NW+MW-HW)'(MH);
			a_s1  <= a;
			q_s2  <= NW'(sum >> K);
			a_s2  <= a_s1;
			qd_s3 <= q_s2 * NW'(D);
			q_s3  <= q_s2;
			a_s3  <= a_s2;
			if (r_est >= NW'(D)) begin
				r_s4 <= RW'(r_est - NW'(D));
				q_s4 <= q_s3 + NW'(1);
			end else begin
				r_s4 <= RW'(r_est);
				q_s4 <= q_s3;
			end
		end
	end

	assign q = q_s4;
	assign r = r_s4;

endmodule

### src/assr_ramp.sv
// ----------------------------------------------------------------------------
// assr_ramp - speed slew and clamp with goal state
// Steps the current speed toward the stored goal, clamps it, flags a change
// against the last sent value and stores the goal formed for this tick.
// ----------------------------------------------------------------------------
module assr_ramp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic [14:0]         step,
	input  logic signed [9:0]   goal_new,
	input  logic signed [8:0]   angle_error,
	input  logic [7:0]          max_speed,
	output assr_pkg::res_t      res
);
	import assr_pkg::*;

	logic signed [9:0]  goal_q, now_q, last_q;
	logic signed [10:0] diff, mv, nxt, lim, clamped;
	logic [9:0]         absd, mvu;

	always_comb begin
		diff = 11'(goal_q) - 11'(now_q);
		absd = 10'(diff < 0 ? -diff : diff);
		mvu  = ({5'b0, absd} < step) ? absd : 10'(step);
		mv   = $signed({1'b0, mvu});
		nxt  = (diff > 0) ? 11'(now_q) + mv : 11'(now_q) - mv;
		lim  = $signed({3'b0, max_speed});
		if (nxt > lim) begin
			clamped = lim;
		end else if (nxt < -lim) begin
			clamped = -lim;
		end else begin
			clamped = nxt;
		end
		res.motor_speed = 9'(clamped);
		res.speed_sent  = (10'(clamped) != last_q);
		res.angle_error = angle_error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q <= '0;
			now_q  <= '0;
			last_q <= '0;
		end else if (upd) begin
			goal_q <= goal_new;
			now_q  <= 10'(clamped);
			last_q <= 10'(clamped);
		end
	end

endmodule

### src/assr_obuf.sv
// ----------------------------------------------------------------------------
// assr_obuf - output register with skid entry
// Lets the pipeline keep moving while one result waits to be taken; the
// pipeline stops only when the skid entry is occupied as well.
// ----------------------------------------------------------------------------
module assr_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  assr_pkg::res_t  din,
	output logic            space,
	output logic            valid,
	input  logic            ready,
	output assr_pkg::res_t  dout
);
	import assr_pkg::*;

	logic main_vld_q, skid_vld_q;
	res_t main_q, skid_q;
	logic take;

	assign take  = main_vld_q && ready;
	assign space = !skid_vld_q;
	assign valid = main_vld_q;
	assign dout  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (push) begin
				if (!main_vld_q || take) begin
					main_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (take) begin
				main_vld_q <= skid_vld_q;
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_vld_q || take) begin
				main_q <= din;
			end else begin
				skid_q <= din;
			end
		end else if (take && skid_vld_q) begin
			main_q <= skid_q;
		end
	end

endmodule

### src/angle_seek_speed_ramp.sv
// ----------------------------------------------------------------------------
// angle_seek_speed_ramp - proportional angle seek with slew-limited speed
// Turns an encoder total into a wrapped angle error, maps it to a speed goal
// and ramps the motor drive toward the goal set by the previous tick.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// -------  ---  -------------------  ----------------------------------------
// s_       in   s_tvalid / s_tready  encoder_total, target_angle, elapsed_ms
// m_       out  m_tvalid / m_tready  motor_speed, angle_error; speed_sent
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One transaction can be taken in every clock cycle while the skid entry is
// free; most of the pipeline depth comes from the two constant dividers that
// form the remainder and the Q8 angle.
// The speed state is updated in a single stage, so consecutive ticks follow
// one another without gaps. Reset clears the valid flags, the speed state and
// the registers to their defaults. When the output is stalled, one further
// result is held in a skid entry before the whole pipeline freezes.
// ----------------------------------------------------------------------------
module angle_seek_speed_ramp #(
	parameter int TICKS_PER_TURN = assr_pkg::TICKS_PER_TURN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] encoder_total, [48:32] target_angle, [56:49] elapsed_ms, rest zero
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] motor_speed, [17:9] angle_error, rest zero
	output logic [23:0] m_tdata,
	// [0] speed_sent
	output logic        m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import assr_pkg::*;

	localparam int RW  = $clog2(TICKS_PER_TURN);
	localparam int NWB = RW + Q8_TURN_BITS;
	localparam int NSTG = 14;
	localparam logic signed [19:0] X_FULL = 20'(FULL_TURN_Q8);
	localparam logic signed [19:0] X_HALF = 20'(HALF_TURN_Q8);

	// Fields that ride alongside the two dividers.
	typedef struct packed {
		logic              neg;
		logic signed [16:0] target;
		logic [7:0]        ms;
	} side_t;

	cfg_t cfg;
	res_t res, res_out;

	logic                en, push;
	logic [NSTG:1]       vld_q;
	logic signed [31:0]  total_s1;
	logic signed [16:0]  target_s1;
	logic [7:0]          ms_s1;
	side_t               side_s1;
	side_t               side_q [2:11];
	logic [31:0]         abs_total;
	logic [RW-1:0]       rem_a;
	logic [NWB-1:0]      b_s6;
	logic [NWB-1:0]      q_b;
	logic signed [17:0]  cur;
	logic signed [19:0]  x, xmod;
	logic signed [17:0]  w_s11, wb;
	logic signed [8:0]   e, e_s12, e_s13, e_s14;
	logic [7:0]          mag, mag_s12, mag_s13;
	logic signed [8:0]   span;
	logic signed [17:0]  p_s12;
	logic [23:0]         acc_s12;
	logic [15:0]         pa;
	logic                psgn_s13;
	logic [31:0]         prod_s13;
	logic [48:0]         stp_s13;
	logic [7:0]          q180;
	logic signed [9:0]   mq, m, goal, goal_s14;
	logic [14:0]         step_s14;

	// The whole pipeline moves while the skid entry is free.
	assign s_tready = en;
	assign push     = vld_q[NSTG] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-1:1], s_tvalid};
		end
	end

	assr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		if (en) begin
			total_s1  <= s_tdata[31:0];
			target_s1 <= s_tdata[48:32];
			ms_s1     <= s_tdata[56:49];
		end
	end

	assign side_s1   = '{neg: total_s1[31], target: target_s1, ms: ms_s1};
	assign abs_total = total_s1[31] ? 32'(-total_s1) : 32'(total_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[2] <= side_s1;
			for (int k = 3; k <= 11; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Stages 2 to 5: remainder of the encoder magnitude by the turn length.
	assr_cdiv #(
		.NW (32),
		.D  (TICKS_PER_TURN)
	) u_div_turn (
		.clk (clk),
		.en  (en),
		.a   (abs_total),
		.q   (),
		.r   (rem_a)
	);

	// Stage 6: scale the remainder to Q8 degrees of a full turn.
	always_ff @(posedge clk) begin
		if (en) begin
			b_s6 <= NWB'(rem_a) * NWB'(FULL_TURN_Q8);
		end
	end

	// Stages 7 to 10: divide back by the turn length for the angle magnitude.
	assr_cdiv #(
		.NW (NWB),
		.D  (TICKS_PER_TURN)
	) u_div_angle (
		.clk (clk),
		.en  (en),
		.a   (b_s6),
		.q   (q_b),
		.r   ()
	);

	// Stage 11: the remainder keeps the sign of the total; the error is then
	// brought into the half-open range of minus to plus half a turn.
	always_comb begin
		cur = side_q[10].neg ? -$signed({1'b0, q_b[16:0]}) : $signed({1'b0, q_b[16:0]});
		x   = 20'(cur) - 20'(side_q[10].target) + X_HALF;
		if (x < -X_FULL) begin
			xmod = x + X_FULL + X_FULL;
		end else if (x < 20'sd0) begin
			xmod = x + X_FULL;
		end else if (x < X_FULL) begin
			xmod = x;
		end else if (x < X_FULL + X_FULL) begin
			xmod = x - X_FULL;
		end else begin
			xmod = x - X_FULL - X_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s11 <= 18'(xmod - X_HALF);
		end
	end

	// Stage 12: whole degrees toward zero, the span product of the map and the ramp step product.
	always_comb begin
		wb   = w_s11 + ((w_s11 < 18'sd0) ? 18'sd255 : 18'sd0);
		e    = 9'(wb >>> 8);
		mag  = 8'(e < 9'sd0 ? -e : e);
		span = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s12   <= e;
			mag_s12 <= mag;
			p_s12   <= 18'($signed({1'b0, mag})) * 18'(span);
			acc_s12 <= 24'(cfg.accel_rate) * 24'(side_q[11].ms);
		end
	end

	// Stage 13: the divisions by 180 and by 1000 as reciprocal products.
	assign pa = 16'(p_s12[17] ? -p_s12 : p_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s13    <= e_s12;
			mag_s13  <= mag_s12;
			psgn_s13 <= p_s12[17];
			prod_s13 <= 32'(pa) * 32'(RECIP_180);
			stp_s13  <= 49'(acc_s12) * 49'(RECIP_1000);
		end
	end

	// Stage 14: the new speed goal, zero inside the deadband.
	always_comb begin
		q180 = prod_s13[SHIFT_180+7:SHIFT_180];
		mq   = psgn_s13 ? -$signed({2'b0, q180}) : $signed({2'b0, q180});
		m    = mq + $signed({2'b0, cfg.min_speed});
		if (mag_s13 <= {4'b0, cfg.deadband}) begin
			goal = '0;
		end else if (e_s13 < 9'sd0) begin
			goal = -m;
		end else begin
			goal = m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s14    <= e_s13;
			goal_s14 <= goal;
			step_s14 <= stp_s13[SHIFT_1000+14:SHIFT_1000];
		end
	end

	// The ramp uses the goal left by the previous tick and stores this one's.
	assr_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (push),
		.step        (step_s14),
		.goal_new    (goal_s14),
		.angle_error (e_s14),
		.max_speed   (cfg.max_speed),
		.res         (res)
	);

	assr_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.space  (en),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.dout   (res_out)
	);

	assign m_tdata = {6'b0, res_out.angle_error, res_out.motor_speed};
	assign m_tuser = res_out.speed_sent;

	// The skid entry can only be filled behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		u_obuf.skid_vld_q |-> m_tvalid)
		else $error("skid entry occupied with no result in the output register");

	// The wrapped error stays within half a turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[11] |-> (w_s11 >= -18'sd46080 && w_s11 <= 18'sd46079))
		else $error("wrapped angle error out of range");

	// Whole-degree error never leaves minus 180 to plus 179.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[12] |-> (e_s12 >= -9'sd180 && e_s12 <= 9'sd179))
		else $error("degree error out of range");

	// Every result carries a speed within the clamp.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (res.motor_speed <= $signed({1'b0, cfg.max_speed})
			&& res.motor_speed >= -$signed({1'b0, cfg.max_speed})))
		else $error("motor speed beyond the clamp");

endmodule

### bench/angle_seek_speed_ramp_chk.sv
// ----------------------------------------------------------------------------
// angle_seek_speed_ramp_chk - result checker for the angle seek speed ramp
// Watches the tick, result and register channels, predicts each result from
// its own copy of the speed state and the settings, and compares every result
// transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module angle_seek_speed_ramp_chk #(
	parameter int TICKS_PER_TURN = assr_pkg::TICKS_PER_TURN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [31:0] encoder_total, [48:32] target_angle, [56:49] elapsed_ms, rest zero
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] motor_speed, [17:9] angle_error, rest zero
	input  logic [23:0] m_tdata,
	// [0] speed_sent
	input  logic        m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);
	import assr_pkg::*;

	cfg_t              settings;
	logic signed [9:0] goal_speed;
	logic signed [9:0] drive_speed;
	logic signed [9:0] reported_speed;
	res_t              awaited_results[$];
	int                results_seen;

	function automatic void report(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	// One control tick: ramp toward the goal left by the previous tick, clamp,
	// then derive the wrapped error and the goal for the next tick.
	function automatic res_t advance_tick(input logic signed [31:0] total,
			input logic signed [16:0] target, input logic [7:0] ms);
		int     speed, ramp_step, gap, gap_mag, move, lim;
		int     err_deg, err_mag, span, goal_mag;
		longint turn_rem, angle_q8, wrap_q8;
		res_t   r;
		speed = drive_speed;
		lim   = int'(settings.max_speed);
		if (goal_speed != drive_speed) begin
			ramp_step = (int'(settings.accel_rate) * int'(ms)) / 1000;
			gap       = goal_speed - drive_speed;
			gap_mag   = gap < 0 ? -gap : gap;
			move      = gap_mag < ramp_step ? gap_mag : ramp_step;
			speed     = speed + (gap > 0 ? move : -move);
		end
		if (speed > lim)
			speed = lim;
		if (speed < -lim)
			speed = -lim;
		drive_speed  = 10'(speed);
		r.speed_sent = 1'b0;
		if (drive_speed != reported_speed) begin
			r.speed_sent   = 1'b1;
			reported_speed = drive_speed;
		end

		// Remainder and division both truncate toward zero.
		turn_rem = longint'(total) % TICKS_PER_TURN;
		angle_q8 = (turn_rem * FULL_TURN_Q8) / TICKS_PER_TURN;
		wrap_q8  = (angle_q8 - longint'(target) + HALF_TURN_Q8) % FULL_TURN_Q8;
		wrap_q8  = wrap_q8 - HALF_TURN_Q8;
		if (wrap_q8 < -HALF_TURN_Q8)
			wrap_q8 = wrap_q8 + FULL_TURN_Q8;
		err_deg = int'(wrap_q8 / 256);

		err_mag = err_deg < 0 ? -err_deg : err_deg;
		if (err_mag <= int'(settings.deadband)) begin
			goal_speed = '0;
		end else begin
			span       = int'(settings.max_speed) - int'(settings.min_speed);
			goal_mag   = (err_mag * span) / 180 + int'(settings.min_speed);
			goal_speed = 10'(err_deg >= 0 ? goal_mag : -goal_mag);
		end

		r.motor_speed = 9'(speed);
		r.angle_error = 9'(err_deg);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want, got;
		if (!arst_n) begin
			settings.max_speed  = MAX_SPEED_RST;
			settings.accel_rate = ACCEL_RATE_RST;
			settings.min_speed  = MIN_SPEED_RST;
			settings.deadband   = DEADBAND_RST;
			goal_speed     = '0;
			drive_speed    = '0;
			reported_speed = '0;
			awaited_results.delete();
			outstanding  = 0;
			results_seen = 0;
			fail_count   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.motor_speed = m_tdata[8:0];
				got.angle_error = m_tdata[17:9];
				got.speed_sent  = m_tuser;
				if (awaited_results.size() == 0) begin
					report($sformatf("result %0d arrived with no tick outstanding",
						results_seen));
				end else begin
					want = awaited_results.pop_front();
					if (got !== want)
						report($sformatf({"result %0d differs (expected/actual):",
							" speed %0d/%0d sent %0d/%0d error %0d/%0d"},
							results_seen, want.motor_speed, got.motor_speed,
							want.speed_sent, got.speed_sent,
							want.angle_error, got.angle_error));
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_SPEED:  settings.max_speed  = cfg_data[7:0];
					CFG_ACCEL_RATE: settings.accel_rate = cfg_data;
					CFG_MIN_SPEED:  settings.min_speed  = cfg_data[7:0];
					CFG_DEADBAND:   settings.deadband   = cfg_data[3:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(advance_tick(s_tdata[31:0], s_tdata[48:32],
					s_tdata[56:49]));
			outstanding = awaited_results.size();
		end
	end

endmodule

### bench/angle_seek_speed_ramp_tb.sv
// ----------------------------------------------------------------------------
// angle_seek_speed_ramp_tb - testbench for the angle seek speed ramp
// Drives directed and random control ticks under a range of register
// settings and output stalls; a separate checker predicts and compares every
// result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module angle_seek_speed_ramp_tb;
	import assr_pkg::*;

	// The run is short; the limit leaves a wide margin over the slowest case,
	// in which every result waits out the receiver's stalls and long hold-off.
	localparam int LIMIT_CYCLES   = 400000;
	localparam int HOLD_CYCLES    = 300;
	localparam int BLOCK_TICKS    = 150;
	localparam int SETTING_BLOCKS = 10;
	// Tail wait after the final drain, before the verdict.
	localparam int SETTLE_CYCLES  = 40;
	// Register indexes from here up have no register behind them.
	localparam int FIRST_UNMAPPED = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// [31:0] encoder_total, [48:32] target_angle, [56:49] elapsed_ms, rest zero
	logic [63:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// [8:0] motor_speed, [17:9] angle_error, rest zero
	logic [23:0] m_tdata;
	// [0] speed_sent
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	int fail_count;
	int outstanding;
	int cycle_count  = 0;
	int tx_gap_pct   = 0;
	int rx_stall_pct = 0;
	int hold_seq     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;

	// Running encoder position and target, so that most random ticks form a
	// believable seek rather than unrelated jumps.
	int                 trk_total  = 0;
	logic signed [16:0] trk_target = '0;

	angle_seek_speed_ramp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	angle_seek_speed_ramp_chk u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("angle_seek_speed_ramp: mismatch");
			$finish;
		end
	end

	// Result receiver. It stalls at random with the current probability, and
	// whenever the stimulus bumps hold_seq it holds off for a long stretch so
	// that the pipeline and its skid entry fill and the input is pushed back.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Offers one tick, after any random idle cycles, and returns at the rising
	// edge where the transaction is taken. The ready flag is sampled on the
	// falling edge, where it is settled, so no race with the block's outputs.
	task automatic send_tick(input logic signed [31:0] total,
			input logic signed [16:0] target, input logic [7:0] ms);
		while ($urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, ms, target, total};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [7:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// Writes all four registers, then one index that maps to nothing, which
	// must leave the settings untouched.
	task automatic apply_settings(input int max_spd, input int accel,
			input int min_spd, input int dband);
		cfg_write(CFG_MAX_SPEED, 16'(max_spd));
		cfg_write(CFG_ACCEL_RATE, 16'(accel));
		cfg_write(CFG_MIN_SPEED, 16'(min_spd));
		cfg_write(CFG_DEADBAND, 16'(dband));
		cfg_write(8'($urandom_range(FIRST_UNMAPPED, 255)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Stops offering ticks until every predicted result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Most ticks nudge the running encoder position so the speed has time to
	// ramp and settle; the rest jump anywhere in the full field ranges or within one turn.
	task automatic send_random_tick();
		int         pick;
		logic [7:0] ms;
		pick = $urandom_range(99);
		if (pick < 70) begin
			trk_total = trk_total + int'($urandom_range(200)) - 100;
			if ($urandom_range(9) == 0)
				trk_target = trk_target + 17'(int'($urandom_range(2048)) - 1024);
		end else if (pick < 85) begin
			trk_total  = int'($urandom);
			trk_target = 17'($urandom);
		end else begin
			trk_total  = int'($urandom_range(2 * TICKS_PER_TURN_DEF)) - TICKS_PER_TURN_DEF;
			trk_target = 17'(int'($urandom_range(FULL_TURN_Q8)) - HALF_TURN_Q8);
		end
		pick = $urandom_range(99);
		if (pick < 5)
			ms = '0;
		else if (pick < 65)
			ms = 8'($urandom_range(30));
		else
			ms = 8'($urandom);
		send_tick(trk_total, trk_target, ms);
	endtask

	initial begin
		int blk;
		int n;
		// First idling mode: sender idles lightly, receiver stalls often.
		tx_gap_pct = 24;
		rx_stall_pct <= 64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks under the reset settings. A ninety degree error sets
		// a goal; the next tick has no elapsed time, so the speed stays put,
		// then a short step, then a step that overshoots and lands on the goal,
		// then a tick with the goal already reached.
		send_tick(32'sd0, 17'sd0, 8'd0);
		send_tick(32'sd0, -17'sd23040, 8'd0);
		send_tick(32'sd0, -17'sd23040, 8'd0);
		send_tick(32'sd0, -17'sd23040, 8'd10);
		send_tick(32'sd0, -17'sd23040, 8'd255);
		send_tick(32'sd0, -17'sd23040, 8'd50);
		// Half a turn either way, and targets beyond half a turn.
		send_tick(32'sd0, 17'sd46080, 8'd1);
		send_tick(32'sd0, -17'sd46080, 8'd3);
		send_tick(32'sd0, 17'sd65535, 8'd255);
		send_tick(32'sd0, -17'sd65536, 8'd255);
		// Encoder extremes and points close to whole and half turns.
		send_tick(32'sh7fffffff, 17'sd0, 8'd255);
		send_tick(32'sh80000000, 17'sd0, 8'd128);
		send_tick(32'sd9842, 17'sd0, 8'd7);
		send_tick(-32'sd9842, 17'sd0, 8'd7);
		send_tick(32'sd4921, 17'sd0, 8'd20);
		send_tick(-32'sd4922, 17'sd0, 8'd20);
		// Errors either side of the deadband edge and just inside the wrap.
		send_tick(32'sd0, -17'sd256, 8'd15);
		send_tick(32'sd0, -17'sd512, 8'd15);
		send_tick(32'sd0, 17'sd256, 8'd15);
		send_tick(32'sd0, 17'sd511, 8'd15);
		send_tick(32'sd0, -17'sd46079, 8'd40);

		for (blk = 0; blk < SETTING_BLOCKS; blk++) begin
			// Registers change only once every result is home.
			drain();
			case (blk)
				1: apply_settings(255, 65535, 0, 0);
				// No acceleration and a zero clamp, with the map running downward.
				2: apply_settings(0, 0, 255, 15);
				3: apply_settings(100, 5000, 200, 3);
				9: apply_settings(255, 4000, 255, 0);
				default:
					if (blk > 0)
						apply_settings($urandom_range(255), $urandom_range(65535),
							$urandom_range(255), $urandom_range(15));
			endcase
			if (blk == 4) begin
				tx_gap_pct = 64;
				rx_stall_pct <= 24;
			end else if (blk == 7) begin
				tx_gap_pct = 0;
				rx_stall_pct <= 0;
			end
			// Long receiver hold-off while the sender keeps offering ticks.
			if (blk == 3)
				hold_seq <= hold_seq + 1;
			for (n = 0; n < BLOCK_TICKS; n++) begin
				// One mid-block pause with the settings unchanged.
				if (blk == 5 && n == BLOCK_TICKS / 2)
					drain();
				send_random_tick();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("angle_seek_speed_ramp: match");
		else
			$display("angle_seek_speed_ramp: mismatch");
		$finish;
	end

endmodule
